/* sv/fpv_pkg.sv */
// shared types and codes for the page framebuffer viewport
package fpv_pkg;

  // operation codes on the request func field
  localparam logic [2:0] FUNC_SET_PIXEL   = 3'd0;
  localparam logic [2:0] FUNC_CLEAR_PIXEL = 3'd1;
  localparam logic [2:0] FUNC_WRITE_BYTE  = 3'd2;
  localparam logic [2:0] FUNC_READ_BYTE   = 3'd3;
  localparam logic [2:0] FUNC_SCROLL      = 3'd4;
  localparam logic [2:0] FUNC_CLEAR_ALL   = 3'd5;

  // scroll directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_NOP,
    OP_SET,
    OP_CLR,
    OP_WRITE,
    OP_READ,
    OP_WIPE,
    OP_OOR
  } op_t;

  // queued command word: canvas column and page already resolved
  typedef struct packed {
    op_t        op;
    logic [7:0] col;
    logic [3:0] page;
    logic [7:0] data;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MODIFY,
    BK_CLEAR
  } bk_state_t;

endpackage

/* sv/fpv_req_if.sv */
// request channel: one operation word per handshake
interface fpv_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] x;
  logic [6:0] y;
  logic [7:0] byte_data;
  logic [1:0] direction;
  logic [7:0] step;
  logic       wrap;

  modport source (output valid, func, x, y, byte_data, direction, step, wrap, input ready);
  modport sink (input valid, func, x, y, byte_data, direction, step, wrap, output ready);
endinterface

/* sv/fpv_rsp_if.sv */
// response channel: one result word per handshake
interface fpv_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       out_of_range;

  modport source (output valid, read_data, out_of_range, input ready);
  modport sink (input valid, read_data, out_of_range, output ready);
endinterface

/* sv/fpv_front.sv */
// front end: accepts requests, owns the viewport offsets, resolves canvas addresses
module fpv_front #(
  parameter int CANVAS_COLS  = 256,
  parameter int CANVAS_PAGES = 16,
  parameter int WINDOW_COLS  = 128,
  parameter int WINDOW_PAGES = 4
) (
  input  logic          clk,
  input  logic          rst,
  fpv_req_if.sink       req,
  input  logic          init_busy,
  output logic          push_valid,
  input  logic          push_ready,
  output fpv_pkg::cmd_t push_cmd
);

  localparam int COL_LIMIT  = (CANVAS_COLS > WINDOW_COLS) ? CANVAS_COLS - WINDOW_COLS : 0;
  localparam int PAGE_LIMIT = (CANVAS_PAGES > WINDOW_PAGES) ? CANVAS_PAGES - WINDOW_PAGES : 0;
  localparam int COL_HOME   = (CANVAS_COLS / 2 > WINDOW_COLS / 2) ?
                              CANVAS_COLS / 2 - WINDOW_COLS / 2 : 0;
  localparam int PAGE_HOME  = (CANVAS_PAGES / 2 > WINDOW_PAGES / 2) ?
                              CANVAS_PAGES / 2 - WINDOW_PAGES / 2 : 0;

  logic [7:0] column_offset;
  logic [7:0] column_offset_next;
  logic [3:0] page_offset;
  logic [3:0] page_offset_next;

  logic       fire;
  logic [8:0] col;
  logic       col_out;
  logic [4:0] page_pix;
  logic [7:0] page_byte;
  logic [8:0] page_up;
  logic [8:0] col_up;

  // no words taken while the power-up clearing pass runs
  assign req.ready  = push_ready && !init_busy;
  assign push_valid = req.valid && !init_busy;
  assign fire       = req.valid && req.ready;

  // canvas address in both forms
  assign col       = {1'b0, req.x} + {1'b0, column_offset};
  assign col_out   = (col >= 9'(CANVAS_COLS));
  assign page_pix  = {1'b0, req.y[6:3]} + {1'b0, page_offset};
  assign page_byte = {1'b0, req.y} + {4'b0, page_offset};

  // classify the word
  always_comb begin
    push_cmd.op   = fpv_pkg::OP_NOP;
    push_cmd.col  = col[7:0];
    push_cmd.page = page_byte[3:0];
    push_cmd.data = req.byte_data;
    unique case (req.func) inside
      fpv_pkg::FUNC_SET_PIXEL, fpv_pkg::FUNC_CLEAR_PIXEL: begin
        push_cmd.page = page_pix[3:0];
        push_cmd.data = 8'd1 << req.y[2:0];
        if (col_out || (page_pix >= 5'(CANVAS_PAGES))) begin
          push_cmd.op = fpv_pkg::OP_OOR;
        end else if (req.func == fpv_pkg::FUNC_SET_PIXEL) begin
          push_cmd.op = fpv_pkg::OP_SET;
        end else begin
          push_cmd.op = fpv_pkg::OP_CLR;
        end
      end
      fpv_pkg::FUNC_WRITE_BYTE, fpv_pkg::FUNC_READ_BYTE: begin
        if (col_out || (page_byte >= 8'(CANVAS_PAGES))) begin
          push_cmd.op = fpv_pkg::OP_OOR;
        end else if (req.func == fpv_pkg::FUNC_WRITE_BYTE) begin
          push_cmd.op = fpv_pkg::OP_WRITE;
        end else begin
          push_cmd.op = fpv_pkg::OP_READ;
        end
      end
      fpv_pkg::FUNC_CLEAR_ALL: begin
        push_cmd.op = fpv_pkg::OP_WIPE;
      end
      default: begin
        push_cmd.op = fpv_pkg::OP_NOP;
      end
    endcase
  end

  // scroll arithmetic, reaching an edge counts as crossing it
  assign page_up = {5'b0, page_offset} + {1'b0, req.step};
  assign col_up  = {1'b0, column_offset} + {1'b0, req.step};

  always_comb begin
    column_offset_next = column_offset;
    page_offset_next   = page_offset;
    if (fire && (req.func == fpv_pkg::FUNC_CLEAR_ALL)) begin
      column_offset_next = 8'(COL_HOME);
      page_offset_next   = 4'(PAGE_HOME);
    end else if (fire && (req.func == fpv_pkg::FUNC_SCROLL)) begin
      case (req.direction)
        fpv_pkg::DIR_UP: begin
          if (page_up >= 9'(PAGE_LIMIT)) begin
            page_offset_next = req.wrap ? 4'd0 : 4'(PAGE_LIMIT);
          end else begin
            page_offset_next = page_up[3:0];
          end
        end
        fpv_pkg::DIR_DOWN: begin
          if ({4'b0, page_offset} <= req.step) begin
            page_offset_next = req.wrap ? 4'(PAGE_LIMIT) : 4'd0;
          end else begin
            page_offset_next = page_offset - req.step[3:0];
          end
        end
        fpv_pkg::DIR_LEFT: begin
          if (col_up >= 9'(COL_LIMIT)) begin
            column_offset_next = req.wrap ? 8'd0 : 8'(COL_LIMIT);
          end else begin
            column_offset_next = col_up[7:0];
          end
        end
        default: begin
          if (column_offset <= req.step) begin
            column_offset_next = req.wrap ? 8'(COL_LIMIT) : 8'd0;
          end else begin
            column_offset_next = column_offset - req.step;
          end
        end
      endcase
    end
  end

  // viewport offset registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset <= 8'(COL_HOME);
      page_offset   <= 4'(PAGE_HOME);
    end else begin
      column_offset <= column_offset_next;
      page_offset   <= page_offset_next;
    end
  end

endmodule

/* sv/fpv_queue.sv */
// short command queue between front and back
module fpv_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  fpv_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output fpv_pkg::cmd_t pop_cmd
);

  localparam int DEPTH = fpv_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fpv_pkg::cmd_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/fpv_back.sv */
// back end: canvas memory, read-modify-write sequencer, clearing sweep, result register
module fpv_back #(
  parameter int CANVAS_COLS  = 256,
  parameter int CANVAS_PAGES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  fpv_pkg::cmd_t pop_cmd,
  output logic          init_busy,
  fpv_rsp_if.source     rsp
);

  localparam int DEPTH = CANVAS_COLS * CANVAS_PAGES;
  localparam int IDX_W = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data;

  fpv_pkg::bk_state_t state;
  fpv_pkg::bk_state_t state_next;
  fpv_pkg::cmd_t      cmd_q;
  logic [IDX_W-1:0]   clr_cnt;
  logic               clr_report;
  logic               out_valid;
  logic [7:0]         out_rd;
  logic               out_oor;

  logic             out_free;
  logic             fire;
  logic             clr_last;
  logic [IDX_W-1:0] pop_idx;
  logic [IDX_W-1:0] cmd_idx;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic             cmd_load;
  logic             load_out;
  logic [7:0]       load_rd;
  logic             load_oor;

  assign out_free  = !out_valid || rsp.ready;
  assign fire      = pop_valid && pop_ready;
  assign clr_last  = (clr_cnt == IDX_W'(DEPTH - 1));
  assign pop_idx   = IDX_W'(int'(pop_cmd.page) * CANVAS_COLS + int'(pop_cmd.col));
  assign cmd_idx   = IDX_W'(int'(cmd_q.page) * CANVAS_COLS + int'(cmd_q.col));
  assign init_busy = (state == fpv_pkg::BK_CLEAR) && !clr_report;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fpv_pkg::BK_IDLE: begin
        if (fire) begin
          case (pop_cmd.op) inside
            fpv_pkg::OP_SET, fpv_pkg::OP_CLR, fpv_pkg::OP_READ: begin
              state_next = fpv_pkg::BK_MODIFY;
            end
            fpv_pkg::OP_WIPE: state_next = fpv_pkg::BK_CLEAR;
            default: state_next = fpv_pkg::BK_IDLE;
          endcase
        end
      end
      fpv_pkg::BK_MODIFY: begin
        state_next = fpv_pkg::BK_IDLE;
      end
      fpv_pkg::BK_CLEAR: begin
        if (clr_last) begin
          state_next = fpv_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = fpv_pkg::BK_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_ready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pop_idx;
    mem_wdata = pop_cmd.data;
    mem_re    = 1'b0;
    cmd_load  = 1'b0;
    load_out  = 1'b0;
    load_rd   = 8'd0;
    load_oor  = 1'b0;
    unique case (state)
      fpv_pkg::BK_IDLE: begin
        pop_ready = out_free;
        if (pop_valid && out_free) begin
          unique case (pop_cmd.op) inside
            fpv_pkg::OP_SET, fpv_pkg::OP_CLR, fpv_pkg::OP_READ: begin
              mem_re   = 1'b1;
              cmd_load = 1'b1;
            end
            fpv_pkg::OP_WRITE: begin
              mem_we   = 1'b1;
              load_out = 1'b1;
            end
            fpv_pkg::OP_OOR: begin
              load_out = 1'b1;
              load_oor = 1'b1;
            end
            fpv_pkg::OP_WIPE: begin
              cmd_load = 1'b1;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      fpv_pkg::BK_MODIFY: begin
        load_out = 1'b1;
        if (cmd_q.op == fpv_pkg::OP_READ) begin
          load_rd = rd_data;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cmd_idx;
          mem_wdata = (cmd_q.op == fpv_pkg::OP_SET) ? (rd_data | cmd_q.data) :
                                                      (rd_data & ~cmd_q.data);
        end
      end
      fpv_pkg::BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = 8'd0;
        load_out  = clr_last && clr_report;
      end
      default: begin
        pop_ready = 1'b0;
      end
    endcase
  end

  // canvas memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[pop_idx];
    end
  end

  // sequencer control, power-up starts with an unreported sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fpv_pkg::BK_CLEAR;
      clr_cnt    <= '0;
      clr_report <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_load && (pop_cmd.op == fpv_pkg::OP_WIPE)) begin
        clr_report <= 1'b1;
      end
      if (state == fpv_pkg::BK_CLEAR) begin
        clr_cnt <= clr_last ? '0 : clr_cnt + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // latched command and result payload
  always_ff @(posedge clk) begin
    if (cmd_load) begin
      cmd_q <= pop_cmd;
    end
    if (load_out) begin
      out_rd  <= load_rd;
      out_oor <= load_oor;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_data    = out_rd;
  assign rsp.out_of_range = out_oor;

endmodule

/* sv/page_framebuffer_viewport.sv */
// top level of the page framebuffer viewport
//
//   channel  dir  signals
//   req      in   valid ready func x y byte_data direction step wrap
//   rsp      out  valid ready read_data out_of_range
//
// write byte, scroll and unused codes finish in the back end from the idle state; set pixel,
// clear pixel and read byte go through the modify state (registered read of the canvas memory,
// then write or reply). clear all is taken from the idle state, then one canvas byte is zeroed
// per cycle.
// after reset the same sweep runs with req.ready low.
// a two-word queue lets the front take words while a result waits on a stalled rsp.
module page_framebuffer_viewport #(
  parameter int CANVAS_COLS  = 256,
  parameter int CANVAS_PAGES = 16,
  parameter int WINDOW_COLS  = 128,
  parameter int WINDOW_PAGES = 4
) (
  input logic       clk,
  input logic       rst,
  fpv_req_if.sink   req,
  fpv_rsp_if.source rsp
);

  logic          init_busy;
  logic          q_push_valid;
  logic          q_push_ready;
  fpv_pkg::cmd_t q_push_cmd;
  logic          q_pop_valid;
  logic          q_pop_ready;
  fpv_pkg::cmd_t q_pop_cmd;

  // accept and classify
  fpv_front #(
    .CANVAS_COLS  (CANVAS_COLS),
    .CANVAS_PAGES (CANVAS_PAGES),
    .WINDOW_COLS  (WINDOW_COLS),
    .WINDOW_PAGES (WINDOW_PAGES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .init_busy  (init_busy),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd)
  );

  // command queue
  fpv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_cmd    (q_pop_cmd)
  );

  // execute against the canvas
  fpv_back #(
    .CANVAS_COLS  (CANVAS_COLS),
    .CANVAS_PAGES (CANVAS_PAGES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_cmd   (q_pop_cmd),
    .init_busy (init_busy),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // no word is taken during the power-up sweep
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !req.ready)
    else $error("request taken during power-up clearing pass");

  // the queue stays empty while the power-up sweep runs
  a_queue_empty_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !q_pop_valid)
    else $error("queue holds a word during power-up clearing pass");

  // leaving reset starts the sweep
  a_sweep_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> init_busy)
    else $error("clearing pass not running after reset");

  // an out of range result never carries data
  a_oor_zero_data: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.out_of_range) |-> (rsp.read_data == 8'd0))
    else $error("out of range result with nonzero read data");
`endif

endmodule

/* bench/page_framebuffer_viewport_tb.sv */
// self-checking bench for the page framebuffer viewport: random and directed canvas traffic
`timescale 1ns / 100ps

module page_framebuffer_viewport_tb;

  localparam int CANVAS_COLS  = 256;
  localparam int CANVAS_PAGES = 16;
  localparam int WINDOW_COLS  = 128;
  localparam int WINDOW_PAGES = 4;

  localparam int CANVAS_BYTES = CANVAS_COLS * CANVAS_PAGES;
  localparam int COL_LIMIT    = (CANVAS_COLS > WINDOW_COLS) ? CANVAS_COLS - WINDOW_COLS : 0;
  localparam int PAGE_LIMIT   = (CANVAS_PAGES > WINDOW_PAGES) ?
                                CANVAS_PAGES - WINDOW_PAGES : 0;
  localparam int COL_HOME     = (CANVAS_COLS / 2 > WINDOW_COLS / 2) ?
                                CANVAS_COLS / 2 - WINDOW_COLS / 2 : 0;
  localparam int PAGE_HOME    = (CANVAS_PAGES / 2 > WINDOW_PAGES / 2) ?
                                CANVAS_PAGES / 2 - WINDOW_PAGES / 2 : 0;

  // func codes the block treats as no-ops
  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  localparam int RANDOM_OPS   = 1425;
  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int SETTLE_TICKS = 16;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] x;
    logic [6:0] y;
    logic [7:0] byte_data;
    logic [1:0] direction;
    logic [7:0] step;
    logic       wrap;
    logic       drain_first;
  } fb_op_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       out_of_range;
  } fb_reply_t;

  logic clk = 1'b0;
  logic rst;

  fpv_req_if req_ch ();
  fpv_rsp_if rsp_ch ();

  page_framebuffer_viewport #(
    .CANVAS_COLS (CANVAS_COLS),
    .CANVAS_PAGES(CANVAS_PAGES),
    .WINDOW_COLS (WINDOW_COLS),
    .WINDOW_PAGES(WINDOW_PAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #4 clk = ~clk;

  // shadow canvas and viewport
  logic [7:0] canvas_img [0:CANVAS_BYTES-1];
  int         col_ofs;
  int         page_ofs;

  fb_op_t    ops_to_send [$];
  fb_reply_t replies_due [$];
  fb_op_t    in_flight;
  bit        took_op = 1'b0;
  int        ops_taken = 0;
  int        total_ops = 0;
  int        mismatches = 0;
  int        cycle_count = 0;
  int        send_gap = 0;
  int        hold_left = 0;

  function automatic void wipe_canvas();
    foreach (canvas_img[i]) canvas_img[i] = 8'h00;
    col_ofs  = COL_HOME & 'hFF;
    page_ofs = PAGE_HOME & 'hF;
  endfunction

  // up and left: reaching the limit counts as crossing it
  function automatic int scroll_fwd(int ofs, int amount, bit wrap_on, int limit);
    int v;
    v = ofs + amount;
    if (v >= limit) v = wrap_on ? 0 : limit;
    return v;
  endfunction

  // down and right: reaching zero counts as crossing it
  function automatic int scroll_back(int ofs, int amount, bit wrap_on, int limit);
    int v;
    v = ofs - amount;
    if (v <= 0) v = wrap_on ? limit : 0;
    return v;
  endfunction

  // update the shadow canvas for one operation and return the reply it owes
  function automatic fb_reply_t apply_to_canvas(fb_op_t op);
    fb_reply_t  reply;
    int         col;
    int         page;
    int         idx;
    logic [7:0] mask;
    reply = '0;
    col   = int'(op.x) + col_ofs;
    if (op.func == fpv_pkg::FUNC_SET_PIXEL || op.func == fpv_pkg::FUNC_CLEAR_PIXEL)
      page = int'(op.y >> 3) + page_ofs;
    else
      page = int'(op.y) + page_ofs;
    idx  = page * CANVAS_COLS + col;
    mask = 8'h01 << op.y[2:0];
    case (op.func) inside
      fpv_pkg::FUNC_SET_PIXEL, fpv_pkg::FUNC_CLEAR_PIXEL,
      fpv_pkg::FUNC_WRITE_BYTE, fpv_pkg::FUNC_READ_BYTE: begin
        if (col >= CANVAS_COLS || page >= CANVAS_PAGES) begin
          reply.out_of_range = 1'b1;
        end else begin
          case (op.func)
            fpv_pkg::FUNC_SET_PIXEL:   canvas_img[idx] = canvas_img[idx] | mask;
            fpv_pkg::FUNC_CLEAR_PIXEL: canvas_img[idx] = canvas_img[idx] & ~mask;
            fpv_pkg::FUNC_WRITE_BYTE:  canvas_img[idx] = op.byte_data;
            default:                   reply.read_data = canvas_img[idx];
          endcase
        end
      end
      fpv_pkg::FUNC_SCROLL: begin
        case (op.direction)
          fpv_pkg::DIR_UP:
            page_ofs = scroll_fwd(page_ofs, int'(op.step), op.wrap, PAGE_LIMIT) & 'hF;
          fpv_pkg::DIR_DOWN:
            page_ofs = scroll_back(page_ofs, int'(op.step), op.wrap, PAGE_LIMIT) & 'hF;
          fpv_pkg::DIR_LEFT:
            col_ofs = scroll_fwd(col_ofs, int'(op.step), op.wrap, COL_LIMIT) & 'hFF;
          default:
            col_ofs = scroll_back(col_ofs, int'(op.step), op.wrap, COL_LIMIT) & 'hFF;
        endcase
      end
      fpv_pkg::FUNC_CLEAR_ALL: wipe_canvas();
      default: ;
    endcase
    return reply;
  endfunction

  function automatic fb_op_t mk_op(logic [2:0] f, logic [7:0] x, logic [6:0] y,
                                   logic [7:0] data, logic [1:0] dir, logic [7:0] amount,
                                   logic wrap_on);
    fb_op_t op;
    op.func        = f;
    op.x           = x;
    op.y           = y;
    op.byte_data   = data;
    op.direction   = dir;
    op.step        = amount;
    op.wrap        = wrap_on;
    op.drain_first = 1'b0;
    return op;
  endfunction

  // append one directed word to the pending queue
  function automatic void queue_op(logic [2:0] f, logic [7:0] x, logic [6:0] y,
                                   logic [7:0] data, logic [1:0] dir, logic [7:0] amount,
                                   logic wrap_on);
    ops_to_send.push_back(mk_op(f, x, y, data, dir, amount, wrap_on));
  endfunction

  // mostly in-window traffic, a tenth of it over the full field ranges
  function automatic fb_op_t random_op();
    fb_op_t op;
    int     pick;
    op = mk_op(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
               7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
               2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 999);
    if (pick >= 900) begin
      op.func = 3'($urandom_range(0, 3));
      return op;
    end
    if (pick < 250)
      op.func = ($urandom_range(0, 4) < 3) ? fpv_pkg::FUNC_SET_PIXEL : fpv_pkg::FUNC_CLEAR_PIXEL;
    else if (pick < 450)
      op.func = fpv_pkg::FUNC_WRITE_BYTE;
    else if (pick < 700)
      op.func = fpv_pkg::FUNC_READ_BYTE;
    else if (pick < 870)
      op.func = fpv_pkg::FUNC_SCROLL;
    else if (pick < 885)
      op.func = fpv_pkg::FUNC_CLEAR_ALL;
    else
      op.func = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
    case (op.func) inside
      fpv_pkg::FUNC_SET_PIXEL, fpv_pkg::FUNC_CLEAR_PIXEL: begin
        if ($urandom_range(0, 9) < 4) op.x = 8'($urandom_range(0, 15));
        else op.x = 8'($urandom_range(0, WINDOW_COLS - 1));
        op.y = 7'($urandom_range(0, WINDOW_PAGES * 8 - 1));
      end
      fpv_pkg::FUNC_WRITE_BYTE, fpv_pkg::FUNC_READ_BYTE: begin
        if ($urandom_range(0, 9) < 4) op.x = 8'($urandom_range(0, 15));
        else op.x = 8'($urandom_range(0, WINDOW_COLS - 1));
        op.y = 7'($urandom_range(0, WINDOW_PAGES - 1));
      end
      fpv_pkg::FUNC_SCROLL: begin
        if ($urandom_range(0, 9) < 7) op.step = 8'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return op;
  endfunction

  // idle length for either side, with calm stretches that have none
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (((ops_taken / 160) % 3) == 1) return 0;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request driver: next word once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid     <= 1'b0;
      req_ch.func      <= '0;
      req_ch.x         <= '0;
      req_ch.y         <= '0;
      req_ch.byte_data <= '0;
      req_ch.direction <= '0;
      req_ch.step      <= '0;
      req_ch.wrap      <= 1'b0;
    end else if (!req_ch.valid || took_op) begin
      took_op = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        req_ch.valid <= 1'b0;
      end else if (ops_to_send.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (ops_to_send[0].drain_first && replies_due.size() != 0) begin
        req_ch.valid <= 1'b0;
      end else begin
        in_flight = ops_to_send.pop_front();
        req_ch.func      <= in_flight.func;
        req_ch.x         <= in_flight.x;
        req_ch.y         <= in_flight.y;
        req_ch.byte_data <= in_flight.byte_data;
        req_ch.direction <= in_flight.direction;
        req_ch.step      <= in_flight.step;
        req_ch.wrap      <= in_flight.wrap;
        req_ch.valid     <= 1'b1;
        send_gap = idle_len();
      end
    end
  end

  // accepted request word: predict its reply
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      replies_due.push_back(apply_to_canvas(in_flight));
      took_op = 1'b1;
      ops_taken++;
    end
  end

  // response backpressure
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      hold_left = idle_len();
    end
  end

  // response monitor: compare against the oldest predicted reply
  always @(posedge clk) begin : check_replies
    fb_reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: expected none, actual read_data %h out_of_range %b",
                 $time, rsp_ch.read_data, rsp_ch.out_of_range);
      end else begin
        want = replies_due.pop_front();
        if (rsp_ch.read_data !== want.read_data) begin
          mismatches++;
          $display("%0t: read_data mismatch: expected %h actual %h",
                   $time, want.read_data, rsp_ch.read_data);
        end
        if (rsp_ch.out_of_range !== want.out_of_range) begin
          mismatches++;
          $display("%0t: out_of_range mismatch: expected %b actual %b",
                   $time, want.out_of_range, rsp_ch.out_of_range);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d replies outstanding", $time, replies_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus and end of test
  initial begin
    fb_op_t op;
    int     n;
    rst = 1'b1;
    wipe_canvas();

    // directed: edges of the canvas, each op, scroll edges with zero and large steps
    queue_op(fpv_pkg::FUNC_WRITE_BYTE, 8'd0, 7'd0, 8'hFF, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_READ_BYTE, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_CLEAR_PIXEL, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_READ_BYTE, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_SET_PIXEL, 8'd191, 7'd0, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_READ_BYTE, 8'd191, 7'd0, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_WRITE_BYTE, 8'd192, 7'd0, 8'hA5, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_READ_BYTE, 8'd255, 7'd127, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_SET_PIXEL, 8'd0, 7'd127, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_SET_PIXEL, 8'd0, 7'd79, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_READ_BYTE, 8'd0, 7'd9, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_WRITE_BYTE, 8'd0, 7'd10, 8'h3C, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_SCROLL, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_SCROLL, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_UP, 8'd255, 1'b0);
    queue_op(fpv_pkg::FUNC_SCROLL, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b1);
    queue_op(fpv_pkg::FUNC_SCROLL, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_DOWN, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_SCROLL, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_DOWN, 8'd0, 1'b1);
    queue_op(fpv_pkg::FUNC_SCROLL, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_LEFT, 8'd64, 1'b0);
    queue_op(fpv_pkg::FUNC_SCROLL, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_RIGHT, 8'd255, 1'b1);
    queue_op(fpv_pkg::FUNC_SCROLL, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_RIGHT, 8'd200, 1'b0);
    queue_op(fpv_pkg::FUNC_SCROLL, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_RIGHT, 8'd0, 1'b1);
    queue_op(fpv_pkg::FUNC_READ_BYTE, 8'd127, 7'd3, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(FUNC_SPARE_LO, 8'd255, 7'd127, 8'hFF, fpv_pkg::DIR_RIGHT, 8'd255, 1'b1);
    queue_op(FUNC_SPARE_HI, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    // clear all after a full drain
    op = mk_op(fpv_pkg::FUNC_CLEAR_ALL, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    op.drain_first = 1'b1;
    ops_to_send.push_back(op);
    queue_op(fpv_pkg::FUNC_READ_BYTE, 8'd0, 7'd0, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);
    queue_op(fpv_pkg::FUNC_READ_BYTE, 8'd191, 7'd0, 8'h00, fpv_pkg::DIR_UP, 8'd0, 1'b0);

    // random traffic, writes often followed by a read of the same byte
    n = 0;
    while (n < RANDOM_OPS) begin
      op = random_op();
      if ($urandom_range(0, 99) == 0) op.drain_first = 1'b1;
      ops_to_send.push_back(op);
      n++;
      if (op.func == fpv_pkg::FUNC_WRITE_BYTE && $urandom_range(0, 2) == 0) begin
        op.func        = fpv_pkg::FUNC_READ_BYTE;
        op.drain_first = 1'b0;
        ops_to_send.push_back(op);
        n++;
      end
    end
    total_ops = ops_to_send.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (ops_taken != total_ops || replies_due.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
